// ===== src/makt_pkg.sv =====
// package for the mesh application key table
// types, function codes and status codes; no dependencies
package makt_pkg;
	localparam int unsigned SLOTS_DEF = 16;
	localparam int unsigned LIST_MAX = 16;
	localparam int unsigned LIST_BYTES = 24;

	typedef enum logic [2:0] {
		FN_SET = 3'd0, FN_DEL = 3'd1, FN_AID = 3'd2,
		FN_PAIR = 3'd3, FN_LIST = 3'd4, FN_UPD = 3'd5
	} func_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_FULL = 2'd1, ST_DMISS = 2'd2, ST_NF = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_WRITE, S_RES, S_LOUT
	} fsm_t;

	// entry word: net, app, key, aid
	localparam int unsigned ENTRY_W = 12 + 12 + 128 + 6;
endpackage

// ===== src/makt_ram.sv =====
// generic dual port ram with registered read
// no dependencies
module makt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== src/mesh_application_key_table_top.sv =====
// top level of the mesh application key table
// depends on makt_pkg and makt_ram
// a command is answered after one pass over all slots through the ram read port, and set and update
// also pass through the write-back cycle; one command at a time, the next taken in the cycle after
// the last result is accepted; list bytes one per cycle while out_ready is high
// reset clears the valid flags (flip-flops) and the controller; ram contents are not cleared
module mesh_application_key_table_top #(
	parameter int unsigned SLOTS = makt_pkg::SLOTS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [2:0]   func,
	input  logic [11:0]  net_index,
	input  logic [11:0]  app_index,
	input  logic [63:0]  key_lo,
	input  logic [63:0]  key_hi,
	input  logic [5:0]   key_aid,
	input  logic [4:0]   start_slot,
	input  logic [7:0]   byte_budget,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [1:0]   status,
	output logic         found,
	output logic [3:0]   slot,
	output logic [11:0]  hit_app_index,
	output logic [63:0]  hit_key_lo,
	output logic [63:0]  hit_key_hi,
	output logic [7:0]   list_byte,
	output logic         byte_valid,
	output logic [7:0]   list_length,
	output logic         last
);
	localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned CW = AW + 1;
	localparam int unsigned EW = makt_pkg::ENTRY_W;

	makt_pkg::fsm_t state_q, state_d;
	logic [SLOTS-1:0] valid_q;
	logic [2:0]  func_q;
	logic [11:0] net_q, app_q;
	logic [63:0] klo_q, khi_q;
	logic [5:0]  aid_q;
	logic [4:0]  start_q;
	logic [7:0]  budget_q;
	logic [CW-1:0] cnt_q;     // address issued
	logic          rv_q;      // read data valid for slot rs_q
	logic [AW-1:0] rs_q;
	logic          hit_q, free_q;
	logic [AW-1:0] hit_slot_q, free_slot_q;
	logic [11:0]  hit_app_q;
	logic [63:0]  hit_lo_q, hit_hi_q;
	logic [7:0]   buf_q [makt_pkg::LIST_BYTES];
	logic [7:0]   len_q, ocnt_q;
	logic [4:0]   count_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [EW-1:0] wdata, rdata;

	makt_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	logic [11:0] r_net, r_app;
	logic [63:0] r_lo, r_hi;
	logic [5:0]  r_aid;
	assign {r_net, r_app, r_hi, r_lo, r_aid} = rdata;
	assign raddr = cnt_q[AW-1:0];

	logic e_valid, m_net, m_pair, m_aid, m_list;
	always_comb begin
		e_valid = valid_q[rs_q];
		m_net = e_valid && (r_net == net_q);
		m_pair = m_net && (r_app == app_q);
		m_aid = m_net && (r_aid == aid_q) && ({{(5 > AW ? 5 - AW : 0){1'b0}}, rs_q} >= start_q);
		m_list = m_net && ({1'b0, len_q} + 9'd3 <= {1'b0, budget_q})
			&& (count_q < 5'(makt_pkg::LIST_MAX));
	end

	logic scan_end;
	assign scan_end = rv_q && (32'(rs_q) == SLOTS - 1);

	// write target for set or update
	logic [AW-1:0] wslot;
	assign wslot = hit_q ? hit_slot_q : free_slot_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			makt_pkg::S_IDLE: if (in_valid) state_d = makt_pkg::S_SCAN;
			makt_pkg::S_SCAN: if (scan_end) begin
				if (func_q == makt_pkg::FN_LIST && len_q != 8'd0 ||
					func_q == makt_pkg::FN_LIST && m_list)
					state_d = makt_pkg::S_LOUT;
				else if (func_q == makt_pkg::FN_SET || func_q == makt_pkg::FN_UPD)
					state_d = makt_pkg::S_WRITE;
				else state_d = makt_pkg::S_RES;
			end
			makt_pkg::S_WRITE: state_d = makt_pkg::S_RES;
			makt_pkg::S_RES: if (out_ready) state_d = makt_pkg::S_IDLE;
			makt_pkg::S_LOUT: if (out_ready && ocnt_q + 8'd1 == len_q) state_d = makt_pkg::S_IDLE;
			default: state_d = makt_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == makt_pkg::S_IDLE);
		we = (state_q == makt_pkg::S_WRITE) &&
			((func_q == makt_pkg::FN_SET && (hit_q || free_q)) ||
			 (func_q == makt_pkg::FN_UPD && hit_q));
		waddr = wslot;
		wdata = {net_q, app_q, khi_q, klo_q, aid_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= makt_pkg::S_IDLE;
			valid_q <= '0;
			rv_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rv_q <= (state_q == makt_pkg::S_SCAN) && !scan_end && (32'(cnt_q) < SLOTS);
			if (we && func_q == makt_pkg::FN_SET) valid_q[wslot] <= 1'b1;
			if (state_q == makt_pkg::S_RES && out_ready && func_q == makt_pkg::FN_DEL && hit_q)
				valid_q[hit_slot_q] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == makt_pkg::S_IDLE && in_valid) begin
			func_q <= func; net_q <= net_index; app_q <= app_index;
			klo_q <= key_lo; khi_q <= key_hi; aid_q <= key_aid;
			start_q <= start_slot; budget_q <= byte_budget;
			cnt_q <= '0; hit_q <= 1'b0; free_q <= 1'b0;
			len_q <= '0; count_q <= '0; ocnt_q <= '0;
		end
		if (state_q == makt_pkg::S_SCAN) begin
			if (32'(cnt_q) < SLOTS) cnt_q <= cnt_q + CW'(1);
			rs_q <= cnt_q[AW-1:0];
		end
		if (state_q == makt_pkg::S_SCAN && rv_q) begin
			if (!e_valid && !free_q) begin
				free_q <= 1'b1; free_slot_q <= rs_q;
			end
			if (!hit_q && ((func_q == makt_pkg::FN_AID) ? m_aid : m_pair)) begin
				hit_q <= 1'b1; hit_slot_q <= rs_q;
				hit_app_q <= r_app; hit_lo_q <= r_lo; hit_hi_q <= r_hi;
			end
			if (func_q == makt_pkg::FN_LIST && m_list) begin
				// an even index count starts a fresh three-byte group
				if (!count_q[0]) begin
					buf_q[len_q[4:0]] <= r_app[7:0];
					buf_q[len_q[4:0] + 5'd1] <= {4'h0, r_app[11:8]};
					len_q <= len_q + 8'd2;
				end else begin
					buf_q[len_q[4:0] - 5'd1] <= buf_q[len_q[4:0] - 5'd1] | {r_app[3:0], 4'h0};
					buf_q[len_q[4:0]] <= r_app[11:4];
					len_q <= len_q + 8'd1;
				end
				count_q <= count_q + 5'd1;
			end
		end
		if (state_q == makt_pkg::S_WRITE) begin
			hit_app_q <= app_q; hit_lo_q <= klo_q; hit_hi_q <= khi_q;
		end
		if (state_q == makt_pkg::S_LOUT && out_ready) ocnt_q <= ocnt_q + 8'd1;
	end

	// result fields
	logic show;
	always_comb begin
		out_valid = (state_q == makt_pkg::S_RES) || (state_q == makt_pkg::S_LOUT);
		status = makt_pkg::ST_OK; found = 1'b0; show = 1'b0;
		unique case (func_q)
			makt_pkg::FN_SET: begin
				show = hit_q || free_q; found = hit_q;
				if (!show) status = makt_pkg::ST_FULL;
			end
			makt_pkg::FN_DEL: begin
				show = hit_q; found = hit_q;
				if (!hit_q) status = makt_pkg::ST_DMISS;
			end
			makt_pkg::FN_AID, makt_pkg::FN_PAIR: begin
				show = hit_q; found = hit_q;
				if (!hit_q) status = makt_pkg::ST_NF;
			end
			makt_pkg::FN_UPD: begin
				show = hit_q; found = hit_q;
			end
			makt_pkg::FN_LIST: ;
			default: status = makt_pkg::ST_NF;
		endcase
		if (state_q == makt_pkg::S_LOUT) begin
			status = makt_pkg::ST_OK; found = 1'b0; show = 1'b0;
		end
		slot = show ? 4'(func_q == makt_pkg::FN_SET ? wslot : hit_slot_q) : 4'd0;
		hit_app_index = show ? hit_app_q : 12'd0;
		hit_key_lo = show ? hit_lo_q : 64'd0;
		hit_key_hi = show ? hit_hi_q : 64'd0;
		byte_valid = (state_q == makt_pkg::S_LOUT);
		list_byte = byte_valid ? buf_q[ocnt_q[4:0]] : 8'd0;
		last = (state_q == makt_pkg::S_RES) || (ocnt_q + 8'd1 == len_q);
		list_length = (byte_valid && last) ? len_q : 8'd0;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		we |-> state_q == makt_pkg::S_WRITE) else $error("ram write outside write state");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == makt_pkg::S_LOUT |-> len_q != 8'd0 && ocnt_q < len_q)
		else $error("list output beyond length");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");
endmodule

// ===== tb/makt_checker.sv =====
// transaction checker for the mesh application key table
// predicts results from the command stream and compares them; depends on makt_pkg
`timescale 1ns / 100ps

module makt_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic         in_ready,
	input  logic [2:0]   func,
	input  logic [11:0]  net_index,
	input  logic [11:0]  app_index,
	input  logic [63:0]  key_lo,
	input  logic [63:0]  key_hi,
	input  logic [5:0]   key_aid,
	input  logic [4:0]   start_slot,
	input  logic [7:0]   byte_budget,
	input  logic         out_valid,
	input  logic         out_ready,
	input  logic [1:0]   status,
	input  logic         found,
	input  logic [3:0]   slot,
	input  logic [11:0]  hit_app_index,
	input  logic [63:0]  hit_key_lo,
	input  logic [63:0]  hit_key_hi,
	input  logic [7:0]   list_byte,
	input  logic         byte_valid,
	input  logic [7:0]   list_length,
	input  logic         last,
	output int           errors,
	output int           pending
);
	typedef struct packed {
		logic [1:0]  status;
		logic        found;
		logic [3:0]  slot;
		logic [11:0] app;
		logic [63:0] klo;
		logic [63:0] khi;
		logic [7:0]  lbyte;
		logic        bvalid;
		logic [7:0]  llen;
		logic        last;
	} key_result_t;

	localparam int NS = 16;

	logic        tbl_valid [NS];
	logic [11:0] tbl_net [NS];
	logic [11:0] tbl_app [NS];
	logic [63:0] tbl_klo [NS];
	logic [63:0] tbl_khi [NS];
	logic [5:0]  tbl_aid [NS];

	key_result_t awaited_results[$];

	assign pending = awaited_results.size();

	function automatic key_result_t entry_result(logic [1:0] st, logic fd, int s);
		key_result_t r;
		r = '0;
		r.status = st;
		r.found = fd;
		r.last = 1'b1;
		if (s >= 0) begin
			r.slot = s[3:0];
			r.app = tbl_app[s];
			r.klo = tbl_klo[s];
			r.khi = tbl_khi[s];
		end
		return r;
	endfunction

	function automatic int find_pair(logic [11:0] net, logic [11:0] app);
		for (int i = 0; i < NS; i++)
			if (tbl_valid[i] && tbl_net[i] == net && tbl_app[i] == app)
				return i;
		return -1;
	endfunction

	task automatic predict_command();
		int m;
		int fs;
		int s;
		int len;
		int cnt;
		logic [7:0] buf_b [24];
		key_result_t r;
		m = find_pair(net_index, app_index);
		case (func)
			makt_pkg::FN_SET: begin
				fs = -1;
				for (int i = NS - 1; i >= 0; i--)
					if (!tbl_valid[i])
						fs = i;
				s = (m >= 0) ? m : fs;
				if (s < 0) begin
					awaited_results.push_back(entry_result(makt_pkg::ST_FULL, 1'b0, -1));
				end else begin
					tbl_valid[s] = 1'b1;
					tbl_net[s] = net_index;
					tbl_app[s] = app_index;
					tbl_klo[s] = key_lo;
					tbl_khi[s] = key_hi;
					tbl_aid[s] = key_aid;
					awaited_results.push_back(entry_result(makt_pkg::ST_OK, m >= 0, s));
				end
			end
			makt_pkg::FN_DEL: begin
				if (m < 0) begin
					awaited_results.push_back(entry_result(makt_pkg::ST_DMISS, 1'b0, -1));
				end else begin
					awaited_results.push_back(entry_result(makt_pkg::ST_OK, 1'b1, m));
					tbl_valid[m] = 1'b0;
				end
			end
			makt_pkg::FN_AID: begin
				s = -1;
				for (int i = NS - 1; i >= int'(start_slot); i--)
					if (tbl_valid[i] && tbl_aid[i] == key_aid && tbl_net[i] == net_index)
						s = i;
				if (s < 0)
					awaited_results.push_back(entry_result(makt_pkg::ST_NF, 1'b0, -1));
				else
					awaited_results.push_back(entry_result(makt_pkg::ST_OK, 1'b1, s));
			end
			makt_pkg::FN_PAIR: begin
				if (m < 0)
					awaited_results.push_back(entry_result(makt_pkg::ST_NF, 1'b0, -1));
				else
					awaited_results.push_back(entry_result(makt_pkg::ST_OK, 1'b1, m));
			end
			makt_pkg::FN_LIST: begin
				len = 0;
				cnt = 0;
				for (int i = 0; i < NS && len + 3 <= int'(byte_budget) &&
						cnt < int'(makt_pkg::LIST_MAX); i++) begin
					if (!(tbl_valid[i] && tbl_net[i] == net_index))
						continue;
					if (len % 3 == 0) begin
						buf_b[len] = tbl_app[i][7:0];
						buf_b[len + 1] = {4'h0, tbl_app[i][11:8]};
						len += 2;
					end else begin
						buf_b[len - 1] = buf_b[len - 1] | {tbl_app[i][3:0], 4'h0};
						buf_b[len] = tbl_app[i][11:4];
						len += 1;
					end
					cnt++;
				end
				if (len == 0) begin
					awaited_results.push_back(entry_result(makt_pkg::ST_OK, 1'b0, -1));
				end else begin
					for (int k = 0; k < len; k++) begin
						r = '0;
						r.lbyte = buf_b[k];
						r.bvalid = 1'b1;
						if (k == len - 1) begin
							r.llen = len[7:0];
							r.last = 1'b1;
						end
						awaited_results.push_back(r);
					end
				end
			end
			makt_pkg::FN_UPD: begin
				if (m >= 0) begin
					tbl_klo[m] = key_lo;
					tbl_khi[m] = key_hi;
					tbl_aid[m] = key_aid;
					awaited_results.push_back(entry_result(makt_pkg::ST_OK, 1'b1, m));
				end else begin
					awaited_results.push_back(entry_result(makt_pkg::ST_OK, 1'b0, -1));
				end
			end
			default: begin
				awaited_results.push_back(entry_result(makt_pkg::ST_NF, 1'b0, -1));
			end
		endcase
	endtask

	task automatic compare_result();
		key_result_t e;
		key_result_t a;
		a = '{status, found, slot, hit_app_index, hit_key_lo, hit_key_hi,
			list_byte, byte_valid, list_length, last};
		if (awaited_results.size() == 0) begin
			$display("%0t: unexpected result transaction %h", $time, a);
			errors++;
		end else begin
			e = awaited_results.pop_front();
			if (a !== e) begin
				$display("%0t: result mismatch expected %h actual %h", $time, e, a);
				errors++;
			end
		end
	endtask

	// output side first so a result never meets the command it belongs to
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			errors = 0;
			awaited_results.delete();
			for (int i = 0; i < NS; i++) begin
				tbl_valid[i] = 1'b0;
				tbl_net[i] = '0;
				tbl_app[i] = '0;
				tbl_klo[i] = '0;
				tbl_khi[i] = '0;
				tbl_aid[i] = '0;
			end
		end else begin
			if (out_valid && out_ready)
				compare_result();
			if (in_valid && in_ready)
				predict_command();
		end
	end
endmodule

// ===== tb/testbench.sv =====
// stimulus and verdict for the mesh application key table
// depends on makt_pkg, mesh_application_key_table_top and makt_checker
`timescale 1ns / 100ps

module testbench;
	logic         clk;
	logic         arst_n;
	logic         in_valid;
	logic         in_ready;
	logic [2:0]   func;
	logic [11:0]  net_index;
	logic [11:0]  app_index;
	logic [63:0]  key_lo;
	logic [63:0]  key_hi;
	logic [5:0]   key_aid;
	logic [4:0]   start_slot;
	logic [7:0]   byte_budget;
	logic         out_valid;
	logic         out_ready;
	logic [1:0]   status;
	logic         found;
	logic [3:0]   slot;
	logic [11:0]  hit_app_index;
	logic [63:0]  hit_key_lo;
	logic [63:0]  hit_key_hi;
	logic [7:0]   list_byte;
	logic         byte_valid;
	logic [7:0]   list_length;
	logic         last;
	int           errors;
	int           pending;
	int           send_idle_pct;
	int           recv_idle_pct;

	mesh_application_key_table_top u_dut (.*);

	makt_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("testbench: FAIL");
		$finish;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// valid stays up after acceptance when the next transaction follows at once
	task automatic send_command(logic [2:0] f, logic [11:0] net, logic [11:0] app,
			logic [63:0] klo, logic [63:0] khi, logic [5:0] aid, logic [4:0] ss,
			logic [7:0] bb);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		func <= f;
		net_index <= net;
		app_index <= app;
		key_lo <= klo;
		key_hi <= khi;
		key_aid <= aid;
		start_slot <= ss;
		byte_budget <= bb;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	function automatic logic [63:0] rand_key();
		return {$urandom(), $urandom()};
	endfunction

	// small pools of nets and apps so sets, hits and lists collide often
	task automatic random_command();
		logic [2:0] f;
		logic [11:0] net;
		logic [11:0] app;
		int pick;
		pick = $urandom_range(99);
		if (pick < 30) f = makt_pkg::FN_SET;
		else if (pick < 45) f = makt_pkg::FN_DEL;
		else if (pick < 60) f = makt_pkg::FN_AID;
		else if (pick < 72) f = makt_pkg::FN_PAIR;
		else if (pick < 85) f = makt_pkg::FN_LIST;
		else if (pick < 96) f = makt_pkg::FN_UPD;
		else f = 3'($urandom_range(7, 6));
		net = ($urandom_range(9) == 0) ? 12'($urandom()) : 12'($urandom_range(3) * 12'h555);
		app = ($urandom_range(3) == 0) ? 12'($urandom()) : 12'($urandom_range(19) * 12'hd3);
		send_command(f, net, app, rand_key(), rand_key(), 6'($urandom_range(7)),
			5'($urandom_range(17)),
			($urandom_range(3) == 0) ? 8'($urandom()) : 8'($urandom_range(30)));
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		func = '0;
		net_index = '0;
		app_index = '0;
		key_lo = '0;
		key_hi = '0;
		key_aid = '0;
		start_slot = '0;
		byte_budget = '0;
		send_idle_pct = 24;
		recv_idle_pct = 58;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table behaviour, then extremes of the fields
		send_command(makt_pkg::FN_LIST, 12'h000, 12'h000, '0, '0, 6'd0, 5'd0, 8'hff);
		send_command(makt_pkg::FN_DEL, 12'hfff, 12'hfff, '0, '0, 6'd0, 5'd0, 8'd0);
		send_command(makt_pkg::FN_SET, 12'hfff, 12'hfff, '1, '1, 6'd63, 5'd31, 8'hff);
		send_command(makt_pkg::FN_SET, 12'h000, 12'h000, '0, '0, 6'd0, 5'd0, 8'd0);
		send_command(makt_pkg::FN_SET, 12'hfff, 12'hfff, 64'h5a5a, 64'ha5a5, 6'd21, 5'd0,
			8'd0);
		send_command(makt_pkg::FN_AID, 12'hfff, 12'h000, '0, '0, 6'd21, 5'd0, 8'd0);
		send_command(makt_pkg::FN_AID, 12'hfff, 12'h000, '0, '0, 6'd21, 5'd16, 8'd0);
		send_command(makt_pkg::FN_AID, 12'hfff, 12'h000, '0, '0, 6'd21, 5'd31, 8'd0);
		send_command(makt_pkg::FN_PAIR, 12'h000, 12'h000, '0, '0, 6'd0, 5'd0, 8'd0);
		send_command(makt_pkg::FN_UPD, 12'h000, 12'h000, '1, '1, 6'd63, 5'd0, 8'd0);
		send_command(makt_pkg::FN_UPD, 12'h123, 12'h456, '1, '1, 6'd63, 5'd0, 8'd0);
		send_command(3'd6, 12'h000, 12'h000, '0, '0, 6'd0, 5'd0, 8'd0);
		send_command(3'd7, 12'hfff, 12'hfff, '1, '1, 6'd63, 5'd31, 8'hff);
		// fill the table to full, mostly on one net, then overflow
		for (int i = 0; i < 15; i++)
			send_command(makt_pkg::FN_SET, 12'h000, 12'(i * 12'h111 + 1), rand_key(),
				rand_key(), 6'(i), 5'd0, 8'd0);
		send_command(makt_pkg::FN_SET, 12'h800, 12'h001, '0, '0, 6'd0, 5'd0, 8'd0);
		// full list, budget cuts including odd trailing index
		send_command(makt_pkg::FN_LIST, 12'h000, 12'h000, '0, '0, 6'd0, 5'd0, 8'hff);
		send_command(makt_pkg::FN_LIST, 12'h000, 12'h000, '0, '0, 6'd0, 5'd0, 8'd5);
		send_command(makt_pkg::FN_LIST, 12'h000, 12'h000, '0, '0, 6'd0, 5'd0, 8'd2);
		send_command(makt_pkg::FN_DEL, 12'h000, 12'h000, '0, '0, 6'd0, 5'd0, 8'd0);
		send_command(makt_pkg::FN_DEL, 12'h000, 12'h000, '0, '0, 6'd0, 5'd0, 8'd0);

		for (int n = 0; n < 330; n++) begin
			if (n == 110) begin
				send_idle_pct = 58;
				recv_idle_pct = 24;
			end else if (n == 220) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			random_command();
		end
		in_valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end
endmodule

// ===== mesh_application_key_table_top.f =====
src/makt_pkg.sv
src/makt_ram.sv
src/mesh_application_key_table_top.sv
tb/makt_checker.sv
tb/testbench.sv
